### rtl/core/i2cmra_pkg.sv
// package: types, phase codes and helpers for the i2c register access master
`default_nettype none
package i2cmra_pkg;

	localparam int CmdW = 3;

	localparam logic [CmdW-1:0] CMD_TICK     = 3'd0;
	localparam logic [CmdW-1:0] CMD_WRITE    = 3'd1;
	localparam logic [CmdW-1:0] CMD_READ     = 3'd2;
	localparam logic [CmdW-1:0] CMD_FIELD    = 3'd3;
	localparam logic [CmdW-1:0] CMD_BIT      = 3'd4;

	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_START_A = 5'd1,
		PH_START_B = 5'd2,
		PH_BYTE0   = 5'd3,
		PH_RS_A    = 5'd19,
		PH_RS_B    = 5'd20,
		PH_RS_C    = 5'd21,
		PH_RX_L    = 5'd22,
		PH_RX_H    = 5'd23,
		PH_MACK_L  = 5'd24,
		PH_MACK_H  = 5'd25,
		PH_STOP_A  = 5'd26,
		PH_STOP_B  = 5'd27,
		PH_STOP_C  = 5'd28
	} phase_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic [2:0] bit_pos;
		logic [3:0] field_len;
		logic [7:0] byte_count;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       last_byte;
		logic       done_res;
		logic       status;
	} result_t;

	typedef struct packed {
		logic       idx;
		logic [15:0] data;
	} cfg_t;

	// read-modify-write of the received byte
	function automatic logic [7:0] modify(input logic [7:0] b, input logic [2:0] op,
			input logic [7:0] val, input logic [2:0] bs, input logic [3:0] len_in);
		logic [7:0] m;
		logic [3:0] len;
		logic [7:0] clr;
		logic [7:0] fld;
		m = 8'd1 << bs;
		len = (len_in > 4'd8) ? 4'd8 : len_in;
		clr = (8'hFF << (4'd8 - len)) >> (3'd7 - bs);
		fld = (val << (4'd8 - len)) >> (3'd7 - bs);
		if (op == CMD_BIT)
			modify = (val != 8'd0) ? (b | m) : (b & ~m);
		else if (len == 4'd0)
			modify = b;
		else
			modify = (b & ~clr) | fld;
	endfunction

endpackage
`default_nettype wire

### rtl/core/i2cmra_if.sv
// interfaces: valid/ready channels for ticks, results and configuration
`default_nettype none
interface i2cmra_tick_if import i2cmra_pkg::*; ();
	logic  valid;
	logic  ready;
	tick_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cmra_res_if import i2cmra_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cmra_cfg_if import i2cmra_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/i2c_master_register_access.sv
// top level: i2c master sequencer for 8-bit register devices, one bus tick per transfer
// channels: tick (sink) carries a command and the sampled sda level; result (source)
// carries scl/sda drive, a received byte and busy/done/status; cfg (sink) writes
// half_period_ticks (index 0) and ack_timeout (index 1), always ready.
// each accepted tick updates the sequencer state and its result is registered:
// result valid in the cycle after the tick transfer, one tick per cycle unless the receiver stalls.
// the result register is a single stage whose slot frees on the same edge it is
// taken, so a tick is accepted whenever the result slot is empty or being taken.
// when the receiver stalls, the result holds and new ticks wait.
// reset clears the sequencer to idle, half_period_ticks to 1, ack_timeout to 1000.
// commands are taken only when idle; others are ignored as plain ticks.
`default_nettype none
module i2c_master_register_access import i2cmra_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	i2cmra_tick_if.sink tick,
	i2cmra_res_if.source res,
	i2cmra_cfg_if.sink  cfg
);

	logic [15:0] half_q, tmo_q;
	phase_t      phase_q, ph, phn;
	logic [15:0] timer_q, timer_n;
	logic [3:0]  bitc_q, bitc_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] ackc_q, ackc_n;
	logic [7:0]  dev_q, dev_n, reg_q, reg_n, val_q, val_n, left_q, left_n;
	logic [2:0]  pos_q, pos_n, op_q, op_n;
	logic [3:0]  len_q, len_n;
	logic        rvalid_q;
	result_t     res_q, r;
	logic        take;
	logic [15:0] h, lim;
	logic        tend;
	logic [4:0]  rel;
	logic [1:0]  k, sub;
	logic [7:0]  rx;
	logic [15:0] ack_inc;

	assign tick.ready = !rvalid_q || res.ready;
	assign take       = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;
	assign res.valid  = rvalid_q;
	assign res.data   = res_q;
	assign h   = (half_q == 16'd0) ? 16'd1 : half_q;
	assign lim = (tmo_q == 16'd0) ? 16'd1 : tmo_q;

	always_comb begin
		ph = (phase_q > PH_STOP_C) ? PH_IDLE : phase_q;
		phn = ph; timer_n = timer_q; bitc_n = bitc_q; shift_n = shift_q; ackc_n = ackc_q;
		dev_n = dev_q; reg_n = reg_q; val_n = val_q; pos_n = pos_q; len_n = len_q;
		left_n = left_q; op_n = op_q;
		r = '0; r.scl_out = 1'b1; r.sda_out = 1'b1;
		rel = 5'd0; k = 2'd0; sub = 2'd0; rx = 8'd0; ack_inc = 16'd0; tend = 1'b0;
		if (ph == PH_IDLE && tick.data.cmd >= CMD_WRITE && tick.data.cmd <= CMD_BIT) begin
			op_n = tick.data.cmd; dev_n = tick.data.dev_addr; reg_n = tick.data.reg_addr;
			val_n = tick.data.wr_data; pos_n = tick.data.bit_pos; len_n = tick.data.field_len;
			left_n = (tick.data.cmd == CMD_READ) ? tick.data.byte_count : 8'd1;
			if (left_n == 8'd0) left_n = 8'd1;
			timer_n = 16'd0; ph = PH_START_A; phn = PH_START_A;
		end
		if (ph != PH_IDLE) begin
			r.busy_res = 1'b1;
			tend = ({1'b0, timer_n} + 17'd1) >= {1'b0, h};
			if (!tend) timer_n = timer_n + 16'd1;
			else timer_n = 16'd0;
			if (ph >= PH_BYTE0 && ph < PH_RS_A) begin
				rel = ph - PH_BYTE0;
				k = rel[3:2]; sub = rel[1:0];
				if (sub <= 2'd1) begin
					r.scl_out = sub[0]; r.sda_out = shift_q[7];
					if (tend) begin
						if (sub == 2'd0) phn = phase_t'(ph + 5'd1);
						else begin
							shift_n = {shift_q[6:0], 1'b0};
							bitc_n = bitc_q + 4'd1;
							phn = (bitc_n >= 4'd8) ? phase_t'(ph + 5'd1) : phase_t'(ph - 5'd1);
						end
					end
				end else if (sub == 2'd2) begin
					r.scl_out = 1'b0;
					if (tend) begin ackc_n = 16'd0; phn = phase_t'(ph + 5'd1); end
				end else begin
					if (!tend) begin
					end else if (!tick.data.sda_in) begin
						bitc_n = 4'd0;
						case (k)
							2'd0: begin shift_n = reg_q; phn = phase_t'(PH_BYTE0 + 5'd4); end
							2'd1: begin
								if (op_q == CMD_WRITE) begin
									shift_n = val_q; phn = phase_t'(PH_BYTE0 + 5'd8);
								end else begin
									bitc_n = bitc_q; phn = PH_RS_A;
								end
							end
							2'd2: begin bitc_n = bitc_q; phn = PH_STOP_A; end
							default: begin shift_n = 8'd0; phn = PH_RX_L; end
						endcase
					end else begin
						timer_n = timer_q;
						ack_inc = (ackc_q != 16'hFFFF) ? ackc_q + 16'd1 : ackc_q;
						ackc_n = ack_inc;
						if (ack_inc >= lim) begin
							timer_n = 16'd0; op_n = CMD_TICK; phn = PH_STOP_A;
						end
					end
				end
			end else begin
				unique case (ph)
					PH_START_B, PH_RS_C: r.sda_out = 1'b0;
					PH_RS_A, PH_RX_L: r.scl_out = 1'b0;
					PH_MACK_L: begin r.scl_out = 1'b0; r.sda_out = !(left_q > 8'd1); end
					PH_MACK_H: r.sda_out = !(left_q > 8'd1);
					PH_STOP_A: begin r.scl_out = 1'b0; r.sda_out = 1'b0; end
					PH_STOP_B: r.sda_out = 1'b0;
					default: ;
				endcase
				if (tend) begin
					unique case (ph)
						PH_START_B: begin
							shift_n = dev_q; bitc_n = 4'd0; phn = PH_BYTE0;
						end
						PH_RS_C: begin
							shift_n = dev_q + 8'd1; bitc_n = 4'd0;
							phn = phase_t'(PH_BYTE0 + 5'd12);
						end
						PH_RX_H: begin
							rx = {shift_q[6:0], tick.data.sda_in};
							shift_n = rx;
							bitc_n = bitc_q + 4'd1;
							if (bitc_n >= 4'd8) begin
								if (op_q == CMD_READ) begin
									r.read_byte = rx; r.byte_valid = 1'b1;
									r.last_byte = left_q <= 8'd1;
								end else
									val_n = modify(rx, op_q, val_q, pos_q, len_q);
								phn = PH_MACK_L;
							end else phn = PH_RX_L;
						end
						PH_MACK_H: begin
							if (left_q > 8'd1) begin
								left_n = left_q - 8'd1; bitc_n = 4'd0; shift_n = 8'd0;
								phn = PH_RX_L;
							end else begin left_n = 8'd0; phn = PH_STOP_A; end
						end
						PH_STOP_C: begin
							if (op_q == CMD_FIELD || op_q == CMD_BIT) begin
								op_n = CMD_WRITE; phn = PH_START_A;
							end else begin
								r.done_res = 1'b1; r.status = (op_q == CMD_TICK);
								op_n = CMD_TICK; phn = PH_IDLE;
							end
						end
						default: phn = phase_t'(ph + 5'd1);
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 16'd1; tmo_q <= 16'd1000;
			phase_q <= PH_IDLE; timer_q <= '0; bitc_q <= '0; shift_q <= '0; ackc_q <= '0;
			dev_q <= '0; reg_q <= '0; val_q <= '0; pos_q <= '0; len_q <= 4'd1;
			left_q <= '0; op_q <= CMD_TICK; rvalid_q <= 1'b0; res_q <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.data.idx == CFG_HALF_PERIOD) half_q <= cfg.data.data;
				else tmo_q <= cfg.data.data;
			end
			if (take) begin
				phase_q <= phn; timer_q <= timer_n; bitc_q <= bitc_n; shift_q <= shift_n;
				ackc_q <= ackc_n; dev_q <= dev_n; reg_q <= reg_n; val_q <= val_n;
				pos_q <= pos_n; len_q <= len_n; left_q <= left_n; op_q <= op_n;
				res_q <= r;
				rvalid_q <= 1'b1;
			end else if (res.ready) rvalid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
